// ===== sv/ising_metropolis_site_update_assert.svh =====
// Assertion macros for the Ising Metropolis site-update block.
// Used by ising_metropolis_site_update.sv; no other dependencies.
`ifndef ISING_METROPOLIS_SITE_UPDATE_ASSERT_SVH
`define ISING_METROPOLIS_SITE_UPDATE_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define ISU_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("ising site update: invariant check failed");

// A condition that implies another in the same cycle.
`define ISU_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ising site update: same-cycle check failed");

// A condition that implies another in the next cycle.
`define ISU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ising site update: next-cycle check failed");

`endif

// ===== sv/isu_pkg.sv =====
// Package for the Ising Metropolis site-update block: sizes, codes and types.
// No dependencies; used by ising_metropolis_site_update.sv.
`timescale 1ns / 1ps

package isu_pkg;

   // Lattice geometry. SIDE must be even so that the neighbors above and
   // below a site always lie in the row bank opposite to the site's own.
   localparam int SIDE        = 64;
   localparam int ROW_W       = $clog2(SIDE);
   localparam int HALF        = SIDE / 2;
   localparam int BANK_W      = ROW_W - 1;
   localparam int RANDOM_BITS = 16;

   // Field widths fixed by the interface.
   localparam int POS_FIELD_W = 6;
   localparam int RND_FIELD_W = 16;
   localparam int TH_W        = 17;
   localparam int DE_W        = 5;
   localparam int MAG_W       = 18;
   localparam int EN_W        = 19;

   // Bus widths.
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 48;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   // Reset values of the running sums.
   localparam logic signed [MAG_W-1:0] MAG_RESET = MAG_W'(SIDE * SIDE);
   localparam logic signed [EN_W-1:0]  EN_RESET  = EN_W'(-2 * SIDE * SIDE);

   // Register indexes, selected by address bit 2.
   typedef enum logic {
      REG_TH_DE4 = 1'b0,
      REG_TH_DE8 = 1'b1
   } csr_reg_type;

   // Item kinds.
   typedef enum logic {
      MODE_LOAD   = 1'b0,
      MODE_UPDATE = 1'b1
   } mode_type;

   typedef logic [SIDE-1:0]  row_bits_type;
   typedef logic [ROW_W-1:0] row_idx_type;
   typedef logic [BANK_W-1:0] bank_idx_type;

   // One item held in the compute stage.
   typedef struct packed {
      mode_type               mode;
      logic                   in_range;
      row_idx_type            row;
      row_idx_type            col;
      row_idx_type            row_up;
      row_idx_type            row_dn;
      logic                   spin_in;
      logic [RANDOM_BITS-1:0] rnd;
   } item_type;

   // Row write seen by the next item's reads at the same edge.
   typedef struct packed {
      logic         en;
      row_idx_type  row;
      row_bits_type data;
   } bypass_type;

   // Periodic neighbor indexes.
   function automatic row_idx_type wrap_dec(row_idx_type i);
      return (i == '0) ? ROW_W'(SIDE - 1) : i - 1'b1;
   endfunction

   function automatic row_idx_type wrap_inc(row_idx_type i);
      return (i == ROW_W'(SIDE - 1)) ? '0 : i + 1'b1;
   endfunction

endpackage

// ===== sv/ising_metropolis_site_update.sv =====
// Top level of the Ising Metropolis site-update block: lattice row banks,
// compute stage, running sums, result register and register port.
// Depends on isu_pkg.sv and ising_metropolis_site_update_assert.svh.
//
//   Channel   Dir  Group                          Moves
//   req       in   tvalid/tready/tdata/tuser      one site word (load or update)
//   rsp       out  tvalid/tready/tdata            one result word per site word
//   csr       in   psel/penable/pwrite/paddr/...  two acceptance thresholds
//
// One word is taken per cycle while the result is not stalled; its result
// passes the registered read of the two row banks and the compute stage
// into the output register. Reset is synchronous: every row reads as all +1
// through a per-row valid bit, so there is no clearing pass. A stalled result
// holds the compute stage: one more word is taken while it waits, and then
// the input stalls until the result leaves.
`timescale 1ns / 1ps
`include "ising_metropolis_site_update_assert.svh"

module ising_metropolis_site_update (
   input  logic                              clock,
   input  logic                              reset,
   // Input words.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [5:0] row, [11:6] col, [12] spin_in, [28:13] random_fraction, rest zero
   input  logic [isu_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [0] mode
   input  logic                              req_tuser,
   // Result words.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] spin_out, [1] flipped, [6:2] energy_change, [24:7] magnetization,
   // [43:25] total_energy, rest zero
   output logic [isu_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // Register port.
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [isu_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [isu_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [isu_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   // Configuration registers.
   logic [isu_pkg::TH_W-1:0] th4_ff;
   logic [isu_pkg::TH_W-1:0] th8_ff;
   isu_pkg::csr_reg_type     csr_sel;

   // Pipeline control.
   logic req_accept;
   logic out_free;
   logic s1_valid_ff;
   logic rsp_valid_ff;
   logic [isu_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic [isu_pkg::RSP_DATA_W-1:0] rsp_data_in;

   // Decoded input word.
   isu_pkg::item_type item_in;
   isu_pkg::item_type s1_ff;

   // Row banks, valid bits and the bypass of the write at the read edge.
   isu_pkg::row_bits_type rd_a_ff [2];
   isu_pkg::row_bits_type rd_b_ff [2];
   logic [isu_pkg::SIDE-1:0] row_vld_ff;
   logic vld_c_ff;
   logic vld_u_ff;
   logic vld_d_ff;
   isu_pkg::bypass_type byp_ff;
   isu_pkg::bypass_type wr;

   // Running sums.
   logic signed [isu_pkg::MAG_W-1:0] mag_ff;
   logic signed [isu_pkg::MAG_W-1:0] mag_in;
   logic signed [isu_pkg::EN_W-1:0]  en_ff;
   logic signed [isu_pkg::EN_W-1:0]  en_in;

   // Compute stage signals.
   isu_pkg::row_bits_type  row_c;
   isu_pkg::row_bits_type  row_u;
   isu_pkg::row_bits_type  row_d;
   isu_pkg::row_idx_type   col_l;
   isu_pkg::row_idx_type   col_r;
   logic                   s_cur;
   logic [2:0]             ones;
   logic [isu_pkg::DE_W-1:0]        ones4;
   logic signed [isu_pkg::DE_W-1:0] de_raw;
   logic signed [isu_pkg::DE_W-1:0] de_out;
   logic                   flip;
   logic                   spin_new;

   // ---------------------------------------------------------------
   // Register port: address bit 2 picks the register.
   // ---------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_sel    = isu_pkg::csr_reg_type'(csr_paddr[2]);

   always_comb begin
      case (csr_sel)
         isu_pkg::REG_TH_DE4: csr_prdata = isu_pkg::CSR_DATA_W'(th4_ff);
         isu_pkg::REG_TH_DE8: csr_prdata = isu_pkg::CSR_DATA_W'(th8_ff);
         default:             csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         th4_ff <= '0;
         th8_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         case (csr_sel)
            isu_pkg::REG_TH_DE4: th4_ff <= csr_pwdata[isu_pkg::TH_W-1:0];
            isu_pkg::REG_TH_DE8: th8_ff <= csr_pwdata[isu_pkg::TH_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Handshake: the compute stage moves on when the output register frees.
   // ---------------------------------------------------------------
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Unpack the input word and compute neighbor rows.
   always_comb begin
      item_in.mode     = isu_pkg::mode_type'(req_tuser);
      item_in.in_range = (int'(req_tdata[5:0]) < isu_pkg::SIDE) &&
                         (int'(req_tdata[11:6]) < isu_pkg::SIDE);
      item_in.row      = isu_pkg::ROW_W'(req_tdata[5:0]);
      item_in.col      = isu_pkg::ROW_W'(req_tdata[11:6]);
      item_in.row_up   = isu_pkg::wrap_dec(item_in.row);
      item_in.row_dn   = isu_pkg::wrap_inc(item_in.row);
      item_in.spin_in  = req_tdata[12];
      item_in.rnd      = req_tdata[13 +: isu_pkg::RANDOM_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_accept;
      end
   end

   // Item payload, valid bits of its rows and the bypass of this edge's write.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ff    <= item_in;
         vld_c_ff <= row_vld_ff[item_in.row];
         vld_u_ff <= row_vld_ff[item_in.row_up];
         vld_d_ff <= row_vld_ff[item_in.row_dn];
         byp_ff   <= wr;
      end
   end

   // ---------------------------------------------------------------
   // Row banks: even rows in bank 0, odd rows in bank 1. Port A reads the
   // center row in its own bank and the upper row in the other; port B
   // reads the lower row.
   // ---------------------------------------------------------------
   for (genvar b = 0; b < 2; b++) begin : g_bank
      isu_pkg::row_bits_type mem [isu_pkg::HALF];
      isu_pkg::bank_idx_type addr_a;
      isu_pkg::bank_idx_type addr_b;

      assign addr_a = (item_in.row[0] == 1'(b)) ? item_in.row[isu_pkg::ROW_W-1:1]
                                                : item_in.row_up[isu_pkg::ROW_W-1:1];
      assign addr_b = item_in.row_dn[isu_pkg::ROW_W-1:1];

      always_ff @(posedge clock) begin
         if (wr.en && (wr.row[0] == 1'(b))) begin
            mem[wr.row[isu_pkg::ROW_W-1:1]] <= wr.data;
         end
         if (req_accept) begin
            rd_a_ff[b] <= mem[addr_a];
            rd_b_ff[b] <= mem[addr_b];
         end
      end
   end

   // Rows never written read as all +1.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff <= '0;
      end else if (wr.en) begin
         row_vld_ff[wr.row] <= 1'b1;
      end
   end

   // ---------------------------------------------------------------
   // Compute stage: pick rows, forward the last write, decide the flip.
   // ---------------------------------------------------------------
   always_comb begin
      row_c = vld_c_ff ? rd_a_ff[s1_ff.row[0]]  : '1;
      row_u = vld_u_ff ? rd_a_ff[~s1_ff.row[0]] : '1;
      row_d = vld_d_ff ? rd_b_ff[~s1_ff.row[0]] : '1;
      if (byp_ff.en && (byp_ff.row == s1_ff.row))    row_c = byp_ff.data;
      if (byp_ff.en && (byp_ff.row == s1_ff.row_up)) row_u = byp_ff.data;
      if (byp_ff.en && (byp_ff.row == s1_ff.row_dn)) row_d = byp_ff.data;

      col_l = isu_pkg::wrap_dec(s1_ff.col);
      col_r = isu_pkg::wrap_inc(s1_ff.col);
      s_cur = row_c[s1_ff.col];

      // Number of +1 neighbors, then dE = 2*s*sum = +/-(4*ones - 8).
      ones  = 3'(row_u[s1_ff.col]) + 3'(row_d[s1_ff.col]) +
              3'(row_c[col_l]) + 3'(row_c[col_r]);
      ones4 = {ones, 2'b00};
      de_raw = s_cur ? $signed(ones4 - isu_pkg::DE_W'(8))
                     : $signed(isu_pkg::DE_W'(8) - ones4);

      case (s1_ff.mode)
         isu_pkg::MODE_LOAD:   flip = (s_cur != s1_ff.spin_in);
         isu_pkg::MODE_UPDATE: begin
            if (de_raw <= 0) begin
               flip = 1'b1;
            end else if (de_raw == isu_pkg::DE_W'(4)) begin
               flip = isu_pkg::TH_W'(s1_ff.rnd) < th4_ff;
            end else begin
               flip = isu_pkg::TH_W'(s1_ff.rnd) < th8_ff;
            end
         end
         default:              flip = 1'b0;
      endcase
      if (!s1_ff.in_range) flip = 1'b0;

      spin_new = s1_ff.in_range && (flip ? !s_cur : s_cur);
      de_out   = flip ? de_raw : '0;

      // Row write-back with the site bit inverted.
      wr.en   = s1_valid_ff && out_free && flip;
      wr.row  = s1_ff.row;
      wr.data = row_c;
      wr.data[s1_ff.col] = !s_cur;

      mag_in = s_cur ? mag_ff - isu_pkg::MAG_W'(2) : mag_ff + isu_pkg::MAG_W'(2);
      en_in  = en_ff + isu_pkg::EN_W'(de_raw);
      if (!wr.en) begin
         mag_in = mag_ff;
         en_in  = en_ff;
      end

      rsp_data_in = {4'b0000, en_in, mag_in, de_out, flip, spin_new};
   end

   // Running sums.
   always_ff @(posedge clock) begin
      if (reset) begin
         mag_ff <= isu_pkg::MAG_RESET;
         en_ff  <= isu_pkg::EN_RESET;
      end else begin
         mag_ff <= mag_in;
         en_ff  <= en_in;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && out_free) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // ---------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------
   // Spin flips move magnetization by 2 and energy by a multiple of 4.
   `ISU_ASSERT_ALWAYS(a_sum_parity, clock, reset, (mag_ff[0] == 1'b0) && (en_ff[1:0] == 2'b00))
   // A stalled item stays in the compute stage.
   `ISU_ASSERT_NEXT(a_stall_keeps_item, clock, reset, s1_valid_ff && !out_free, s1_valid_ff)
   // A result without a flip reports no energy change.
   `ISU_ASSERT_IMPL(a_no_flip_de, clock, reset, rsp_tvalid && !rsp_tdata[1], rsp_tdata[6:2] == '0)

endmodule
